@@ sv/ppa_pkg.sv @@
`default_nettype none
package ppa_pkg;
  localparam int MAX_DEGREE_D   = 16;
  localparam int MAX_SEGMENTS_D = 64;
  localparam int TABLE_WORDS_D  = 1153;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 11;
  localparam int SEG_W   = 6;
  localparam int DEG_W   = 5;
  localparam int CNT_W   = 7;

  localparam logic [CFG_W-1:0] REG_DEGREE = 7'd0;
  localparam logic [CFG_W-1:0] REG_COUNT  = 7'd1;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [31:0] QNAN32 = 32'h7FC00000;
  localparam logic [31:0] INF32  = 32'h7F800000;

  typedef struct packed {
    logic        rd_en;
    logic        clr_x;
    logic        cmp_lo;
    logic        cmp_hi;
    logic        ld_acc;
    logic        fma_go;
  } ppa_cmd_t;

  typedef struct packed {
    logic fma_done;
  } ppa_sts_t;

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > INF32[30:0];
  endfunction

  function automatic logic [31:0] okey(input logic [31:0] v);
    logic [31:0] w;
    w = (v[30:0] == 31'd0) ? 32'd0 : v;
    return w[31] ? ~w : (w | 32'h80000000);
  endfunction

  // Ordered a < b; false with any NaN.
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && (okey(a) < okey(b));
  endfunction
endpackage
`default_nettype wire

@@ sv/ppa_if.sv @@
`default_nettype none
interface ppa_in_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic        action;
  logic [10:0] table_index;
  logic [31:0] value_bits;
  modport source (output valid, action, table_index, value_bits, input ready);
  modport sink   (input valid, action, table_index, value_bits, output ready);
endinterface

interface ppa_out_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] poly_value;
  logic [5:0]  segment_used;
  modport source (output valid, poly_value, segment_used, input ready);
  modport sink   (input valid, poly_value, segment_used, output ready);
endinterface
`default_nettype wire

@@ sv/piecewise_polynomial_activation.sv @@
`default_nettype none
// Piecewise polynomial activation on float32 values.
// Input channel: each transfer is either a table load (action 0), which writes
// value_bits into table word table_index if it lies in the table and produces
// no result, or an evaluation (action 1) of x = value_bits, which produces one
// result on the output channel: the float32 polynomial value and the segment
// chosen. A load leaves the block free for the next item. An evaluation holds
// the block for one table read per boundary for the clamp and the segment
// search, then one pass of the multi-cycle fused multiply-add unit per degree,
// since the table RAM read port and the fma unit are shared.
// The result is held in the output register until the receiver takes it;
// while it waits no further item is accepted.
// Reset clears the control and sets the degree to 3 and the segment count to
// 16. The table holds no defined contents after reset; load every word before
// it is used.
// The user must make configuration writes only while the block is idle; the block itself does not enforce it.
module piecewise_polynomial_activation #(
  parameter int MAX_DEGREE   = ppa_pkg::MAX_DEGREE_D,
  parameter int MAX_SEGMENTS = ppa_pkg::MAX_SEGMENTS_D,
  parameter int TABLE_WORDS  = ppa_pkg::TABLE_WORDS_D
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  ppa_in_if.sink                         in_ch,
  ppa_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [ppa_pkg::CFG_W-1:0] cfg_index,
  input  wire logic [ppa_pkg::CFG_W-1:0] cfg_data
);
  localparam int AW = $clog2(TABLE_WORDS);
  logic [ppa_pkg::DEG_W-1:0] deg_r;
  logic [ppa_pkg::CNT_W-1:0] cnt_r;
  logic [31:0] x_r, rd_data, acc;
  logic busy, start, ge_seg, wr_en;
  logic [AW-1:0] rd_addr;
  ppa_pkg::ppa_cmd_t cmd;
  ppa_pkg::ppa_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 5'd3;
      cnt_r <= 7'd16;
    end else if (cfg_we) begin
      if (cfg_index == ppa_pkg::REG_DEGREE) deg_r <= cfg_data[ppa_pkg::DEG_W-1:0];
      else if (cfg_index == ppa_pkg::REG_COUNT) cnt_r <= cfg_data;
    end
  end

  assign in_ch.ready = !busy;
  assign start = in_ch.valid && !busy && in_ch.action == ppa_pkg::ACT_EVAL;
  assign wr_en = in_ch.valid && !busy && in_ch.action == ppa_pkg::ACT_LOAD &&
                 (32'(in_ch.table_index) < 32'(TABLE_WORDS));

  always_ff @(posedge clk) if (start) x_r <= in_ch.value_bits;

  ppa_ctrl #(.MAX_DEGREE(MAX_DEGREE), .MAX_SEGMENTS(MAX_SEGMENTS),
             .TABLE_WORDS(TABLE_WORDS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .deg_cfg(deg_r), .cnt_cfg(cnt_r),
    .ge_seg(ge_seg), .sts(sts), .out_taken(out_ch.ready), .cmd(cmd),
    .rd_addr(rd_addr), .busy(busy), .res_valid(out_ch.valid),
    .seg_r(out_ch.segment_used));

  ppa_datapath #(.TABLE_WORDS(TABLE_WORDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .wr_en(wr_en),
    .wr_addr(in_ch.table_index[AW-1:0]), .wr_data(in_ch.value_bits),
    .rd_addr(rd_addr), .x_in(start ? in_ch.value_bits : x_r), .rd_data(rd_data),
    .ge_seg(ge_seg), .acc_r(acc));

  assign out_ch.poly_value = acc;
endmodule
`default_nettype wire

@@ sv/ppa_ram.sv @@
`default_nettype none
module ppa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1153
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/ppa_fma.sv @@
`default_nettype none
// Multi-cycle fp32 fused multiply-add: unpack/multiply, align, add, normalize, round.
module ppa_fma (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  output logic             done,
  output logic      [31:0] res
);
  typedef enum logic [2:0] {F_IDLE, F_MUL, F_ALIGN, F_ADD, F_NORM, F_ROUND} fst_t;
  fst_t st_r;
  logic        spec_r;
  logic [31:0] spec_val_r;
  logic        cz_r;
  logic [47:0] p_r;
  logic signed [10:0] ep_r, ey_r, ex_r;
  logic [63:0] x_r, y_r, s_r;
  logic        sx_r, sy_r, rs_r;
  logic [31:0] cb_r;
  logic        zero_r;
  logic [5:0]  tb_r;

  function automatic logic [5:0] topb(input logic [63:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) if (v[i]) p = 6'(i);
    return p;
  endfunction

  function automatic logic [63:0] shrs(input logic [63:0] v, input int d);
    logic [63:0] m;
    if (d <= 0) return v;
    if (d >= 64) return {63'd0, |v};
    m = (64'd1 << d) - 64'd1;
    return (v >> d) | {63'd0, |(v & m)};
  endfunction

  logic        a_z, b_z, c_z, any_nan;
  logic [7:0]  ea, eb, ec;
  logic        sp;
  always_comb begin
    ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
    a_z = a[30:0] == 31'd0; b_z = b[30:0] == 31'd0; c_z = c[30:0] == 31'd0;
    sp = a[31] ^ b[31];
    any_nan = ppa_pkg::is_nan(a) || ppa_pkg::is_nan(b) || ppa_pkg::is_nan(c);
  end

  // Rounding of sign * sig * 2^e.
  function automatic logic [31:0] rpack(input logic s, input logic [63:0] sig,
                                        input int e, input int p);
    int be, sh;
    logic [63:0] q, rem, half, bits;
    be = p + e + 127;
    sh = (be >= 1) ? (p - 23) : (-149 - e);
    if (sh <= 0) q = sig << (-sh);
    else if (sh >= 64) q = (sh == 64 && sig > 64'h8000000000000000) ? 64'd1 : 64'd0;
    else begin
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q = sig >> sh;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    bits = (be >= 1) ? ((64'(be - 1) << 23) + q) : q;
    if (bits >= 64'(ppa_pkg::INF32)) bits = 64'(ppa_pkg::INF32);
    return {s, bits[30:0]};
  endfunction

  logic [23:0] ma, mb;
  assign ma = {ea != 8'd0, a[22:0]};
  assign mb = {eb != 8'd0, b[22:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st_r)
        F_IDLE: if (go) begin
          spec_r <= 1'b1;
          cz_r <= c_z;
          sx_r <= sp; sy_r <= c[31]; cb_r <= c;
          p_r <= ma * mb;
          ep_r <= 11'(int'(ea == 8'd0 ? 8'd1 : ea) + int'(eb == 8'd0 ? 8'd1 : eb) - 300);
          ey_r <= 11'(int'(ec == 8'd0 ? 8'd1 : ec) - 150);
          if (any_nan) spec_val_r <= ppa_pkg::QNAN32;
          else if (ea == 8'hFF || eb == 8'hFF) begin
            if (a_z || b_z) spec_val_r <= ppa_pkg::QNAN32;
            else if (ec == 8'hFF && c[31] != sp) spec_val_r <= ppa_pkg::QNAN32;
            else spec_val_r <= {sp, ppa_pkg::INF32[30:0]};
          end else if (ec == 8'hFF) spec_val_r <= c;
          else if (a_z || b_z) spec_val_r <= c_z ? ((sp == c[31]) ? {sp, 31'd0} : 32'd0) : c;
          else spec_r <= 1'b0;
          st_r <= F_MUL;
        end
        F_MUL: begin
          x_r <= 64'(p_r) << (61 - int'(topb(64'(p_r))));
          ex_r <= 11'(int'(ep_r) - (61 - int'(topb(64'(p_r)))));
          y_r <= 64'({ cb_r[30:23] != 8'd0, cb_r[22:0] }) <<
                 (61 - int'(topb(64'({cb_r[30:23] != 8'd0, cb_r[22:0]}))));
          ey_r <= 11'(int'(ey_r) -
                 (61 - int'(topb(64'({cb_r[30:23] != 8'd0, cb_r[22:0]})))));
          st_r <= F_ALIGN;
        end
        F_ALIGN: begin
          // With a zero addend the product sign must stay in sx_r.
          if (!cz_r && ex_r < ey_r) begin
            x_r <= y_r; ex_r <= ey_r; sx_r <= sy_r;
            y_r <= shrs(x_r, int'(ey_r) - int'(ex_r)); sy_r <= sx_r;
          end else y_r <= shrs(y_r, int'(ex_r) - int'(ey_r));
          st_r <= F_ADD;
        end
        F_ADD: begin
          zero_r <= 1'b0;
          if (sx_r == sy_r) begin s_r <= x_r + y_r; rs_r <= sx_r; end
          else if (x_r > y_r) begin s_r <= x_r - y_r; rs_r <= sx_r; end
          else if (y_r > x_r) begin s_r <= y_r - x_r; rs_r <= sy_r; end
          else zero_r <= 1'b1;
          st_r <= F_NORM;
        end
        F_NORM: begin
          tb_r <= cz_r ? topb(64'(p_r)) : topb(s_r);
          st_r <= F_ROUND;
        end
        F_ROUND: begin
          if (spec_r) res <= spec_val_r;
          else if (cz_r) res <= rpack(sx_r, 64'(p_r), int'(ep_r), int'(tb_r));
          else if (zero_r) res <= 32'd0;
          else res <= rpack(rs_r, s_r, int'(ex_r), int'(tb_r));
          done <= 1'b1;
          st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/ppa_datapath.sv @@
`default_nettype none
module ppa_datapath #(
  parameter int TABLE_WORDS = ppa_pkg::TABLE_WORDS_D,
  parameter int AW = $clog2(TABLE_WORDS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ppa_pkg::ppa_cmd_t cmd,
  output ppa_pkg::ppa_sts_t     sts,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [31:0]      wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic [31:0]      x_in,
  output logic      [31:0]      rd_data,
  output logic                  ge_seg,
  output logic      [31:0]      acc_r
);
  logic [31:0] xc_r, fma_res;
  logic        fdone;

  ppa_ram #(.WIDTH(32), .DEPTH(TABLE_WORDS)) u_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(rd_data));

  // Clamped x >= boundary, ordered.
  assign ge_seg = !ppa_pkg::is_nan(xc_r) && !ppa_pkg::is_nan(rd_data) &&
                  (ppa_pkg::okey(xc_r) >= ppa_pkg::okey(rd_data));

  always_ff @(posedge clk) begin
    if (cmd.clr_x) xc_r <= x_in;
    else if (cmd.cmp_lo && ppa_pkg::fp_lt(xc_r, rd_data)) xc_r <= rd_data;
    else if (cmd.cmp_hi && ppa_pkg::fp_lt(rd_data, xc_r)) xc_r <= rd_data;
    if (cmd.ld_acc) acc_r <= rd_data;
    else if (fdone) acc_r <= fma_res;
  end

  ppa_fma u_fma (.clk(clk), .rst_n(rst_n), .go(cmd.fma_go), .a(acc_r), .b(x_in),
                 .c(rd_data), .done(fdone), .res(fma_res));
  assign sts.fma_done = fdone;
endmodule
`default_nettype wire

@@ sv/ppa_ctrl.sv @@
`default_nettype none
module ppa_ctrl #(
  parameter int MAX_DEGREE   = ppa_pkg::MAX_DEGREE_D,
  parameter int MAX_SEGMENTS = ppa_pkg::MAX_SEGMENTS_D,
  parameter int TABLE_WORDS  = ppa_pkg::TABLE_WORDS_D,
  parameter int AW = $clog2(TABLE_WORDS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [ppa_pkg::DEG_W-1:0] deg_cfg,
  input  wire logic [ppa_pkg::CNT_W-1:0] cnt_cfg,
  input  wire logic                     ge_seg,
  input  wire ppa_pkg::ppa_sts_t        sts,
  input  wire logic                     out_taken,
  output ppa_pkg::ppa_cmd_t             cmd,
  output logic      [AW-1:0]            rd_addr,
  output logic                          busy,
  output logic                          res_valid,
  output logic      [ppa_pkg::SEG_W-1:0] seg_r
);
  typedef enum logic [2:0] {S_IDLE, S_LO, S_HI, S_SEG, S_TOP, S_FMA, S_WAIT, S_OUT} st_t;
  localparam int SW = $clog2(MAX_SEGMENTS + 1);
  localparam int DW = $clog2(MAX_DEGREE + 2);
  st_t st_r;
  logic [SW-1:0] cnt_r, s_r;
  logic [DW-1:0] deg_r, k_r;
  logic [AW+1:0] base_r, addr_w;
  logic          pend_r;

  always_comb begin
    cmd = '0;
    addr_w = '0;
    case (st_r)
      S_IDLE: begin cmd.rd_en = start; cmd.clr_x = start; addr_w = '0; end
      S_LO:   begin cmd.rd_en = 1'b1; cmd.cmp_lo = 1'b1; addr_w = (AW+2)'(cnt_r); end
      S_HI:   begin cmd.rd_en = 1'b1; cmd.cmp_hi = 1'b1; addr_w = (AW+2)'(1); end
      S_SEG:  begin
        cmd.rd_en = 1'b1;
        addr_w = (AW+2)'(s_r) + 1'b1;
        if (s_r + 1'b1 >= cnt_r || !pend_r)
          addr_w = (AW+2)'(cnt_r) + 1'b1 +
                   (AW+2)'((pend_r && ge_seg) ? ppa_pkg::SEG_W'(s_r) : seg_r) *
                   (AW+2)'(deg_r + 1'b1) + (AW+2)'(deg_r);
      end
      S_TOP:  begin cmd.ld_acc = 1'b1; cmd.rd_en = 1'b1; addr_w = base_r + (AW+2)'(k_r); end
      S_FMA:  cmd.fma_go = 1'b1;
      // The next lower coefficient is fetched as the current step finishes.
      S_WAIT: begin
        cmd.rd_en = sts.fma_done;
        addr_w = base_r + (AW+2)'(k_r - 1'b1);
      end
      default: ;
    endcase
    rd_addr = (addr_w < (AW+2)'(TABLE_WORDS)) ? addr_w[AW-1:0] : '0;
  end

  assign busy = st_r != S_IDLE;
  assign res_valid = st_r == S_OUT;

  // S_SEG runs one cycle per boundary; the boundary read in the previous cycle is compared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pend_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (start) begin
          cnt_r <= (cnt_cfg == '0) ? SW'(1) :
                   (int'(cnt_cfg) > MAX_SEGMENTS) ? SW'(MAX_SEGMENTS) : SW'(cnt_cfg);
          deg_r <= (int'(deg_cfg) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(deg_cfg);
          seg_r <= '0;
          st_r <= S_LO;
        end
        S_LO: st_r <= S_HI;
        S_HI: begin s_r <= SW'(1); pend_r <= cnt_r > SW'(1); st_r <= S_SEG; end
        S_SEG: begin
          if (pend_r && ge_seg) seg_r <= ppa_pkg::SEG_W'(s_r);
          if (s_r + 1'b1 >= cnt_r || !pend_r) begin
            pend_r <= 1'b0;
            base_r <= (AW+2)'(cnt_r) + 1'b1 +
                      (AW+2)'((pend_r && ge_seg) ? ppa_pkg::SEG_W'(s_r) : seg_r) *
                      (AW+2)'(deg_r + 1'b1);
            k_r <= deg_r - 1'b1;
            st_r <= S_TOP;
          end
          s_r <= s_r + 1'b1;
        end
        S_TOP: st_r <= (deg_r == '0) ? S_OUT : S_FMA;
        S_FMA: st_r <= S_WAIT;
        S_WAIT: if (sts.fma_done) begin
          if (k_r == '0) st_r <= S_OUT;
          else begin k_r <= k_r - 1'b1; st_r <= S_FMA; end
        end
        S_OUT: if (out_taken) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/ppa_checker.sv @@
`default_nettype none
module ppa_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_action,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_poly_value
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result waits");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_poly_value))
    else $error("stalled result changed");
  a_load_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_action |=> !out_valid)
    else $error("load produced a result");
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=> !in_ready)
    else $error("evaluation did not occupy the block");
endmodule

bind piecewise_polynomial_activation ppa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_action(in_ch.action), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_poly_value(out_ch.poly_value));
`default_nettype wire

@@ verif/piecewise_polynomial_activation_tb.sv @@
`timescale 1ns / 100ps
module piecewise_polynomial_activation_tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 4 + ppa_pkg::MAX_SEGMENTS_D + 7 * ppa_pkg::MAX_DEGREE_D + 16;
  localparam int CW = ppa_pkg::CFG_W;

  typedef struct {
    logic [31:0]               value;
    logic [ppa_pkg::SEG_W-1:0] seg;
  } poly_result_t;

  class poly_scoreboard;
    logic [31:0]      words[ppa_pkg::TABLE_WORDS_D];
    int unsigned      degree = 3;
    int unsigned      count  = 16;
    poly_result_t     awaited_q[$];
    int               errors = 0;
    int               evals  = 0;
    int               loads  = 0;
    int               checked = 0;

    function void set_reg(logic [ppa_pkg::CFG_W-1:0] idx, logic [ppa_pkg::CFG_W-1:0] data);
      if (idx == ppa_pkg::REG_DEGREE) degree = data[4:0];
      else if (idx == ppa_pkg::REG_COUNT) count = data;
    endfunction

    function bit nan_word(logic [31:0] v);
      return v[30:0] > 31'h7F800000;
    endfunction

    // Maps a float to an unsigned key that sorts in value order, with -0 as +0.
    function logic [31:0] sort_key(logic [31:0] v);
      logic [31:0] w;
      w = (v[30:0] == 31'd0) ? 32'd0 : v;
      return w[31] ? ~w : (w | 32'h80000000);
    endfunction

    function bit less(logic [31:0] a, logic [31:0] b);
      return !nan_word(a) && !nan_word(b) && (sort_key(a) < sort_key(b));
    endfunction

    function logic [31:0] rd(int unsigned idx);
      return (idx < ppa_pkg::TABLE_WORDS_D) ? words[idx] : 32'd0;
    endfunction

    function int msb64(longint unsigned v);
      int p;
      p = 63;
      while (p > 0 && v[p] == 1'b0) p--;
      return p;
    endfunction

    function longint unsigned shift_sticky(longint unsigned v, int d);
      longint unsigned r;
      if (d <= 0) return v;
      if (d >= 64) return (v != 0) ? 64'd1 : 64'd0;
      r = v >> d;
      if ((v & ((64'd1 << d) - 64'd1)) != 0) r |= 64'd1;
      return r;
    endfunction

    // Rounds sign * sig * 2^e to float32, nearest even; sig is nonzero.
    function logic [31:0] round_float(bit s, longint unsigned sig, int e);
      int p, be, sh;
      longint unsigned q, bits, rem, half;
      p = msb64(sig);
      be = p + e + 127;
      sh = (be >= 1) ? (p - 23) : (-149 - e);
      if (sh <= 0) begin
        q = sig << (-sh);
      end else if (sh >= 64) begin
        q = (sh == 64 && sig > 64'h8000000000000000) ? 64'd1 : 64'd0;
      end else begin
        rem = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        q = sig >> sh;
        if (rem > half || (rem == half && q[0])) q++;
      end
      bits = (be >= 1) ? ((longint'(be - 1) << 23) + q) : q;
      if (bits >= 64'h7F800000) bits = 64'h7F800000;
      return {s, bits[30:0]};
    endfunction

    function logic [31:0] mul_add(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      bit sp, sc, sx, sy, ts, rs, az, bz, cz;
      int ea, eb, ec, ep, ex, ey, ti, sh;
      longint unsigned fa, fb, fc, prod, xs, ys, sum, tu;
      sp = a[31] ^ b[31];
      sc = c[31];
      ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
      fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
      az = a[30:0] == 0; bz = b[30:0] == 0; cz = c[30:0] == 0;
      if (nan_word(a) || nan_word(b) || nan_word(c)) return ppa_pkg::QNAN32;
      if (ea == 255 || eb == 255) begin
        if (az || bz) return ppa_pkg::QNAN32;
        if (ec == 255 && sc != sp) return ppa_pkg::QNAN32;
        return {sp, 31'h7F800000};
      end
      if (ec == 255) return c;
      if (az || bz) begin
        if (cz) return (sp == sc) ? {sp, 31'd0} : 32'd0;
        return c;
      end
      prod = (ea != 0 ? (fa | 64'h800000) : fa) * (eb != 0 ? (fb | 64'h800000) : fb);
      ep = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 300;
      if (cz) return round_float(sp, prod, ep);
      sh = 61 - msb64(prod);
      xs = prod << sh; ex = ep - sh; sx = sp;
      ys = (ec != 0) ? (fc | 64'h800000) : fc;
      sh = 61 - msb64(ys);
      ys = ys << sh; ey = (ec != 0 ? ec : 1) - 150 - sh; sy = sc;
      if (ex < ey) begin
        tu = xs; xs = ys; ys = tu;
        ti = ex; ex = ey; ey = ti;
        ts = sx; sx = sy; sy = ts;
      end
      ys = shift_sticky(ys, ex - ey);
      if (sx == sy) begin
        sum = xs + ys; rs = sx;
      end else if (xs > ys) begin
        sum = xs - ys; rs = sx;
      end else if (ys > xs) begin
        sum = ys - xs; rs = sy;
      end else begin
        return 32'd0;
      end
      return round_float(rs, sum, ex);
    endfunction

    function void note_input(logic act, logic [ppa_pkg::IDX_W-1:0] idx, logic [31:0] v);
      int unsigned deg, cnt, seg, base;
      logic [31:0] lo, hi, xc, acc;
      if (act == ppa_pkg::ACT_LOAD) begin
        loads++;
        if (idx < ppa_pkg::TABLE_WORDS_D) words[idx] = v;
        return;
      end
      evals++;
      deg = (degree > ppa_pkg::MAX_DEGREE_D) ? ppa_pkg::MAX_DEGREE_D : degree;
      cnt = (count == 0) ? 1 :
            ((count > ppa_pkg::MAX_SEGMENTS_D) ? ppa_pkg::MAX_SEGMENTS_D : count);
      lo = rd(0);
      hi = rd(cnt);
      xc = v;
      if (less(xc, lo)) xc = lo;
      if (less(hi, xc)) xc = hi;
      seg = 0;
      for (int unsigned s = 1; s < cnt; s++)
        if (!nan_word(xc) && !nan_word(rd(s)) && !less(xc, rd(s))) seg = s;
      base = cnt + 1 + seg * (deg + 1);
      acc = rd(base + deg);
      for (int k = int'(deg) - 1; k >= 0; k--)
        acc = mul_add(acc, v, rd(base + k));
      awaited_q.push_back('{value: acc, seg: seg[ppa_pkg::SEG_W-1:0]});
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [31:0] value, logic [ppa_pkg::SEG_W-1:0] seg);
      poly_result_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("unexpected result %h seg %0d", value, seg));
        return;
      end
      want = awaited_q.pop_front();
      checked++;
      if (value !== want.value)
        report($sformatf("poly_value %h, expected %h", value, want.value));
      if (seg !== want.seg)
        report($sformatf("segment_used %0d, expected %0d", seg, want.seg));
    endtask

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ppa_pkg::CFG_W-1:0] cfg_index = '0;
  logic [ppa_pkg::CFG_W-1:0] cfg_data = '0;

  ppa_in_if  in_bus (clk);
  ppa_out_if out_bus (clk);

  poly_scoreboard sb = new();
  bit calm = 1'b0;
  int out_stall = 0;
  int idle_cycles = 0;
  logic [31:0] bound_word[ppa_pkg::MAX_SEGMENTS_D + 1];
  int unsigned eff_deg, eff_cnt;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.action = ppa_pkg::ACT_LOAD;
    in_bus.table_index = '0;
    in_bus.value_bits = '0;
    out_bus.ready = 1'b0;
  end

  always #6 clk = ~clk;

  piecewise_polynomial_activation u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.poly_value, out_bus.segment_used);
    if (out_stall > 0) begin
      out_bus.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (out_bus.valid && out_bus.ready) out_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("piecewise_polynomial_activation_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic act, logic [ppa_pkg::IDX_W-1:0] idx, logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.table_index <= idx;
    in_bus.value_bits <= v;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    sb.note_input(act, idx, v);
  endtask

  task automatic wait_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppa_pkg::CFG_W-1:0] idx, logic [ppa_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [31:0] random_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return {1'($urandom), 8'($urandom_range(118, 132)), 23'($urandom)};
    if (r < 92) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'h80000000;
      2: return {1'($urandom), 31'h7F800000};
      default: return ppa_pkg::QNAN32;
    endcase
  endfunction

  // Boundaries come from an ascending run of sort keys mapped back to floats.
  task automatic load_table();
    logic [31:0] k, step;
    int unsigned words;
    k = 32'h80000000 - 32'($urandom_range(0, 32'h40000000));
    step = 32'h80000000 / (eff_cnt + 1);
    for (int unsigned i = 0; i <= eff_cnt; i++) begin
      bound_word[i] = k[31] ? (k ^ 32'h80000000) : ~k;
      if ($urandom_range(0, 199) == 0) bound_word[i] = ppa_pkg::QNAN32;
      send(ppa_pkg::ACT_LOAD, i[ppa_pkg::IDX_W-1:0], bound_word[i]);
      k = k + 32'($urandom_range(1, step));
    end
    words = eff_cnt + 1 + eff_cnt * (eff_deg + 1);
    for (int unsigned i = eff_cnt + 1; i < words; i++)
      send(ppa_pkg::ACT_LOAD, i[ppa_pkg::IDX_W-1:0], random_coef());
  endtask

  function automatic logic [31:0] random_x();
    int r;
    logic [31:0] b;
    r = $urandom_range(0, 99);
    b = bound_word[$urandom_range(0, eff_cnt)];
    if (r < 50) return b + 32'($signed($urandom_range(0, 4000)) - 2000);
    if (r < 65) return b;
    if (r < 85) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h80000000;
      2: return {1'($urandom), 31'h7F800000};
      3: return {1'($urandom), 8'hFF, 1'b1, 22'($urandom)};
      4: return {1'($urandom), 8'd0, 23'($urandom)};
      default: return {1'($urandom), 31'h7F7FFFFF};
    endcase
  endfunction

  int unsigned deg_plan[9] = '{3, 0, 1, 16, 2, 31, 4, 5, 2};
  int unsigned cnt_plan[9] = '{16, 1, 2, 8, 4, 0, 127, 8, 3};
  logic [31:0] edge_x[12] = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                              32'h7FC00000, 32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF,
                              32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800000, 32'hBF800000};

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(ppa_pkg::REG_DEGREE, CW'(deg_plan[ph]));
      write_reg(ppa_pkg::REG_COUNT, CW'(cnt_plan[ph]));
      eff_deg = (deg_plan[ph] > ppa_pkg::MAX_DEGREE_D) ? ppa_pkg::MAX_DEGREE_D : deg_plan[ph];
      eff_cnt = (cnt_plan[ph] == 0) ? 1 :
                ((cnt_plan[ph] > ppa_pkg::MAX_SEGMENTS_D) ? ppa_pkg::MAX_SEGMENTS_D :
                 cnt_plan[ph]);
      calm = (ph == 2);
      load_table();
      if (ph == 0) begin
        foreach (edge_x[i]) send(ppa_pkg::ACT_EVAL, 11'($urandom), edge_x[i]);
        send(ppa_pkg::ACT_EVAL, 11'h7FF, bound_word[0]);
        send(ppa_pkg::ACT_EVAL, 11'h000, bound_word[eff_cnt]);
        send(ppa_pkg::ACT_EVAL, 11'h555, bound_word[5]);
        // Loads past the table end are dropped without effect.
        send(ppa_pkg::ACT_LOAD, 11'h7FF, 32'hFFFFFFFF);
        send(ppa_pkg::ACT_LOAD, 11'(ppa_pkg::TABLE_WORDS_D), 32'h12345678);
      end else if (ph == 2) begin
        // x * 1.0 + (-x) cancels exactly to +0 in segment 1.
        send(ppa_pkg::ACT_LOAD, 11'(eff_cnt + 1 + 2 + 1), 32'h3F800000);
        send(ppa_pkg::ACT_LOAD, 11'(eff_cnt + 1 + 2), bound_word[1] ^ 32'h80000000);
        send(ppa_pkg::ACT_EVAL, 11'd0, bound_word[1]);
        // A NaN boundary neither clamps nor selects its segment.
        send(ppa_pkg::ACT_LOAD, 11'd1, ppa_pkg::QNAN32);
        send(ppa_pkg::ACT_EVAL, 11'd0, bound_word[1]);
        send(ppa_pkg::ACT_LOAD, 11'd1, bound_word[1]);
      end
      n = (eff_deg == ppa_pkg::MAX_DEGREE_D) ? 60 : 83;
      for (int i = 0; i < n; i++) begin
        if (i == n / 2) wait_results();
        if ($urandom_range(0, 9) == 0)
          send(ppa_pkg::ACT_LOAD, 11'($urandom_range(eff_cnt + 1, 2047)), random_coef());
        else
          send(ppa_pkg::ACT_EVAL, 11'($urandom), random_x());
      end
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    $display("covered %0d evaluations and %0d loads over 9 degree/segment settings",
             sb.evals, sb.loads);
    $display("results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("piecewise_polynomial_activation_tb passed");
    else
      $display("piecewise_polynomial_activation_tb failed");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/ppa_pkg.sv
sv/ppa_if.sv
sv/ppa_ram.sv
sv/ppa_fma.sv
sv/ppa_datapath.sv
sv/ppa_ctrl.sv
sv/piecewise_polynomial_activation.sv
sv/ppa_checker.sv
verif/piecewise_polynomial_activation_tb.sv
